>>> rtl/core/ust_pkg.sv
// Shared types and codes for the unordered set table.
// Used by ust_ctrl, ust_dp, unordered_set_table, ust_checker and the testbench; depends on nothing.
package ust_pkg;

  // Default number of table slots.
  localparam int CapacityDefault = 16;

  // Fixed field widths of the word on each channel.
  localparam int ValueW   = 32;
  localparam int ReqW     = 2;
  localparam int SlotW    = 4;
  localparam int StatusW  = 2;
  localparam int CountOutW = 5;

  // Request codes; the unused code is treated as a lookup.
  typedef enum logic [ReqW-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2
  } req_t;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_DONE     = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;    // capture the incoming word
    logic load_match;  // register the parallel compare result
    logic commit;      // update table and count, load the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // the output register can take a new word this cycle
  } dp_stat_t;

endpackage

>>> rtl/core/ust_ctrl.sv
// Controller state machine for the unordered set table.
// Depends on ust_pkg for the state, command and status types.
module ust_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ust_pkg::dp_stat_t  stat,
  output ust_pkg::ctrl_cmd_t cmd
);

  ust_pkg::state_t state_r;
  ust_pkg::state_t state_nxt;

  // A new word enters when idle, or in the update cycle once the result can leave.
  assign in_ready = (state_r == ust_pkg::S_IDLE) ||
                    ((state_r == ust_pkg::S_UPD) && stat.out_free);

  always_comb begin
    cmd.load_req   = in_valid && in_ready;
    cmd.load_match = (state_r == ust_pkg::S_CMP);
    cmd.commit     = (state_r == ust_pkg::S_UPD) && stat.out_free;
  end

  // Next-state logic: compare, then update; the update state holds while the output is stalled.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ust_pkg::S_IDLE: begin
        if (in_valid) state_nxt = ust_pkg::S_CMP;
      end
      ust_pkg::S_CMP: begin
        state_nxt = ust_pkg::S_UPD;
      end
      ust_pkg::S_UPD: begin
        if (stat.out_free) begin
          state_nxt = in_valid ? ust_pkg::S_CMP : ust_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ust_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ust_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/ust_dp.sv
// Datapath for the unordered set table: slot registers, count, parallel
// compare, update logic and the output register. Depends on ust_pkg.
module ust_dp #(
  parameter int CAPACITY = ust_pkg::CapacityDefault
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ust_pkg::ctrl_cmd_t                 cmd,
  output ust_pkg::dp_stat_t                  stat,
  input  logic [ust_pkg::ReqW-1:0]           in_req_type,
  input  logic signed [ust_pkg::ValueW-1:0]  in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic [ust_pkg::SlotW-1:0]          out_slot,
  output logic [ust_pkg::StatusW-1:0]        out_status,
  output logic [ust_pkg::CountOutW-1:0]      out_count_after
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Table contents and count.
  logic [ust_pkg::ValueW-1:0] entries_r [CAPACITY];
  logic [CntW-1:0]            count_r;
  logic [CntW-1:0]            count_nxt;

  // Captured request.
  logic [ust_pkg::ReqW-1:0]   req_r;
  logic [ust_pkg::ValueW-1:0] value_r;

  // Registered compare result.
  logic            hit_r;
  logic [IdxW-1:0] where_r;
  logic            hit_c;
  logic [IdxW-1:0] where_c;

  // Output register.
  logic                            out_valid_r;
  logic                            out_found_r;
  logic [ust_pkg::SlotW-1:0]       out_slot_r;
  logic [ust_pkg::StatusW-1:0]     out_status_r;
  logic [ust_pkg::CountOutW-1:0]   out_count_r;

  // Update decisions.
  logic                            wr_en;
  logic [IdxW-1:0]                 wr_idx;
  logic [ust_pkg::ValueW-1:0]      wr_data;
  logic [IdxW-1:0]                 slot_idx;
  ust_pkg::status_t                status_c;
  logic [IdxW-1:0]                 last_idx;
  logic [IdxW-1:0]                 tail_idx;
  logic [IdxW+ust_pkg::SlotW-1:0]  slot_ext;
  logic [CntW+ust_pkg::CountOutW-1:0] cnt_ext;

  assign stat.out_free = !out_valid_r || out_ready;

  // Capture the incoming word.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r   <= in_req_type;
      value_r <= in_value;
    end
  end

  // Compare every occupied slot at once; the lowest match wins.
  always_comb begin
    hit_c   = 1'b0;
    where_c = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if ((count_r > CntW'(i)) && (entries_r[i] == value_r)) begin
        hit_c   = 1'b1;
        where_c = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_match) begin
      hit_r   <= hit_c;
      where_r <= where_c;
    end
  end

  // Slot indexes for appending and for the last stored entry.
  assign tail_idx = count_r[IdxW-1:0];
  assign last_idx = IdxW'(count_r - CntW'(1));

  // Decide the table update and the result word.
  always_comb begin
    wr_en     = 1'b0;
    wr_idx    = where_r;
    wr_data   = entries_r[last_idx];
    count_nxt = count_r;
    slot_idx  = '0;
    status_c  = ust_pkg::ST_DONE;
    case (req_r)
      ust_pkg::REQ_INSERT: begin
        if (hit_r) begin
          slot_idx = where_r;
          status_c = ust_pkg::ST_NOCHANGE;
        end else if (count_r == CntW'(CAPACITY)) begin
          status_c = ust_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_idx    = tail_idx;
          wr_data   = value_r;
          slot_idx  = tail_idx;
          count_nxt = count_r + CntW'(1);
        end
      end
      ust_pkg::REQ_DELETE: begin
        if (hit_r) begin
          // Move the last entry into the freed slot.
          wr_en     = 1'b1;
          slot_idx  = where_r;
          count_nxt = count_r - CntW'(1);
        end else begin
          status_c = ust_pkg::ST_NOCHANGE;
        end
      end
      default: begin
        if (hit_r) slot_idx = where_r;
      end
    endcase
  end

  assign slot_ext = {{ust_pkg::SlotW{1'b0}}, slot_idx};
  assign cnt_ext  = {{ust_pkg::CountOutW{1'b0}}, count_nxt};

  // Table write on commit.
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      entries_r[wr_idx] <= wr_data;
    end
  end

  // Count and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) count_r <= count_nxt;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output word.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_found_r  <= hit_r;
      out_slot_r   <= slot_ext[ust_pkg::SlotW-1:0];
      out_status_r <= status_c;
      out_count_r  <= cnt_ext[ust_pkg::CountOutW-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_slot        = out_slot_r;
  assign out_status      = out_status_r;
  assign out_count_after = out_count_r;

endmodule

>>> rtl/core/unordered_set_table.sv
// Top level of the unordered set table: controller plus datapath.
// Depends on ust_pkg, ust_ctrl and ust_dp.
//
// Usage:
//   A request word (in_req_type, in_value) enters on the in_ channel with a
//   valid/ready handshake: lookup, insert or delete of a 32-bit signed value.
//   Each request yields exactly one result word on the out_ channel: found,
//   slot, status and the count of stored values after the request.
//   Values are kept packed from slot 0; a delete moves the last entry into
//   the freed slot. An insert into a full table is refused with a full status.
//   An accepted word is registered, compared across all slots in the compare
//   state, and its result is registered in the update state.
//   A new word is taken in the update state as the previous result commits,
//   but not in the compare state.
//   If the receiver stalls, the result waits in the output register and the
//   next word is still compared; its update waits until the output is free.
//   Reset empties the set (count 0), clears the output valid and idles the controller;
//   the block is ready for a word as soon as reset is released.
module unordered_set_table #(
  parameter int CAPACITY = ust_pkg::CapacityDefault
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ust_pkg::ReqW-1:0]           in_req_type,
  input  logic signed [ust_pkg::ValueW-1:0]  in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic [ust_pkg::SlotW-1:0]          out_slot,
  output logic [ust_pkg::StatusW-1:0]        out_status,
  output logic [ust_pkg::CountOutW-1:0]      out_count_after
);

  ust_pkg::ctrl_cmd_t cmd;
  ust_pkg::dp_stat_t  stat;

  ust_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ust_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_req_type),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_slot        (out_slot),
    .out_status      (out_status),
    .out_count_after (out_count_after)
  );

  // One word at a time: the compare cycle after an accept takes no new word.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new word accepted during compare cycle");

  // After the compare state that follows an accept, the update commits unless the output is stalled.
  a_commit_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##2 (cmd.commit || !stat.out_free))
    else $error("update did not follow the compare");

  // The table is never updated while a result still waits to be taken.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> stat.out_free)
    else $error("result overwritten before it was taken");

  // A refused insert never reports a match.
  a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ust_pkg::ST_FULL)) |-> !out_found)
    else $error("full status reported together with a match");

endmodule

>>> dv/ust_checker.sv
// Checker for the unordered set table: watches both channels, keeps its own copy of the set,
// and compares every result word against the prediction. Depends on ust_pkg only.
`timescale 1ns / 1ps

module ust_checker #(
  parameter int CAPACITY = ust_pkg::CapacityDefault
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [ust_pkg::ReqW-1:0]           in_req_type,
  input  logic signed [ust_pkg::ValueW-1:0]  in_value,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               out_found,
  input  logic [ust_pkg::SlotW-1:0]          out_slot,
  input  logic [ust_pkg::StatusW-1:0]        out_status,
  input  logic [ust_pkg::CountOutW-1:0]      out_count_after,
  output int                                 fail_count,
  output int                                 outstanding
);

  typedef struct packed {
    logic                           found;
    logic [ust_pkg::SlotW-1:0]      slot;
    ust_pkg::status_t               status;
    logic [ust_pkg::CountOutW-1:0]  count_after;
  } set_result_t;

  // Predicted contents of the set, packed from slot 0.
  logic signed [ust_pkg::ValueW-1:0] stored_vals [CAPACITY];
  int                                stored_num = 0;

  // Results owed by the block, oldest first.
  set_result_t results_due [$];
  int          errors = 0;

  // Apply one request word to the predicted set and return the result it should give.
  function automatic set_result_t apply_request(logic [ust_pkg::ReqW-1:0] req,
                                                logic signed [ust_pkg::ValueW-1:0] v);
    set_result_t r;
    logic        hit;
    int          where;
    hit   = 1'b0;
    where = 0;
    for (int i = 0; i < stored_num; i++) begin
      if (!hit && stored_vals[i] == v) begin
        hit   = 1'b1;
        where = i;
      end
    end
    r.found  = hit;
    r.slot   = '0;
    r.status = ust_pkg::ST_DONE;
    case (req)
      ust_pkg::REQ_INSERT: begin
        if (hit) begin
          r.slot   = where[ust_pkg::SlotW-1:0];
          r.status = ust_pkg::ST_NOCHANGE;
        end else if (stored_num >= CAPACITY) begin
          r.status = ust_pkg::ST_FULL;
        end else begin
          stored_vals[stored_num] = v;
          r.slot     = stored_num[ust_pkg::SlotW-1:0];
          stored_num = stored_num + 1;
        end
      end
      ust_pkg::REQ_DELETE: begin
        if (hit) begin
          // The last entry fills the hole left by the removed value.
          r.slot             = where[ust_pkg::SlotW-1:0];
          stored_vals[where] = stored_vals[stored_num-1];
          stored_num         = stored_num - 1;
        end else begin
          r.status = ust_pkg::ST_NOCHANGE;
        end
      end
      default: begin
        // Lookups, and the unused code which behaves as one.
        if (hit) begin
          r.slot = where[ust_pkg::SlotW-1:0];
        end
      end
    endcase
    r.count_after = stored_num[ust_pkg::CountOutW-1:0];
    return r;
  endfunction

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      errors++;
    end
  endtask

  // Score result words first, then predict for the request word taken at the same edge.
  always @(posedge clk) begin
    set_result_t due;
    if (!rst_n) begin
      stored_num = 0;
      results_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result word with no request outstanding");
          errors++;
        end else begin
          due = results_due.pop_front();
          check_field("found", due.found, out_found);
          check_field("slot", due.slot, out_slot);
          check_field("status", due.status, out_status);
          check_field("count_after", due.count_after, out_count_after);
        end
      end
      if (in_valid && in_ready) begin
        results_due.push_back(apply_request(in_req_type, in_value));
      end
    end
    fail_count  <= errors;
    outstanding <= results_due.size();
  end

endmodule

>>> dv/tb_unordered_set_table.sv
// Top of the unordered set table testbench: clock, reset, request and receiver drivers.
// Depends on ust_pkg, unordered_set_table and ust_checker, which does all the scoring.
`timescale 1ns / 1ps

module tb_unordered_set_table;

  localparam int                        Capacity   = ust_pkg::CapacityDefault;
  localparam logic [ust_pkg::ReqW-1:0]  ReqUnused  = 2'd3;
  localparam int                        HoldCycles = 150;
  localparam int                        CycleLimit = 200000;
  localparam int                        PoolSize   = 24;
  localparam int                        PhaseItems = 175;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [ust_pkg::ReqW-1:0]            in_req_type = ust_pkg::REQ_LOOKUP;
  logic signed [ust_pkg::ValueW-1:0]   in_value = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic                                out_found;
  logic [ust_pkg::SlotW-1:0]           out_slot;
  logic [ust_pkg::StatusW-1:0]         out_status;
  logic [ust_pkg::CountOutW-1:0]       out_count_after;

  int fail_count;
  int outstanding;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_calls = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;

  logic signed [ust_pkg::ValueW-1:0] value_pool [PoolSize];

  always #6 clk = ~clk;

  unordered_set_table #(.CAPACITY(Capacity)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_slot        (out_slot),
    .out_status      (out_status),
    .out_count_after (out_count_after)
  );

  ust_checker #(.CAPACITY(Capacity)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_slot        (out_slot),
    .out_status      (out_status),
    .out_count_after (out_count_after),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  // Receiver: a long hold-off when one is requested, otherwise random back-pressure.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_calls != hold_served) begin
      hold_served <= hold_calls;
      hold_left   <= HoldCycles;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("unordered_set_table test failed");
      $finish;
    end
  end

  // Offer one request word after a random gap and hold it until it is taken.
  task automatic send_word(logic [ust_pkg::ReqW-1:0] req,
                           logic signed [ust_pkg::ValueW-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Random traffic over a small pool of values, so hits, deletes and a full table are common.
  // The mix drifts between filling and draining the set.
  task automatic run_random(int n_items);
    logic                              fill_tide;
    int                                roll;
    logic [ust_pkg::ReqW-1:0]          req;
    logic signed [ust_pkg::ValueW-1:0] val;
    fill_tide = 1'b1;
    for (int k = 0; k < n_items; k++) begin
      roll = $urandom_range(99);
      if (fill_tide) begin
        req = (roll < 55) ? ust_pkg::REQ_INSERT : (roll < 75) ? ust_pkg::REQ_DELETE :
              (roll < 95) ? ust_pkg::REQ_LOOKUP : ReqUnused;
      end else begin
        req = (roll < 20) ? ust_pkg::REQ_INSERT : (roll < 70) ? ust_pkg::REQ_DELETE :
              (roll < 95) ? ust_pkg::REQ_LOOKUP : ReqUnused;
      end
      if ($urandom_range(99) < 80) begin
        val = value_pool[$urandom_range(PoolSize-1)];
      end else begin
        val = $urandom;
      end
      send_word(req, val);
      if ($urandom_range(29) == 0) begin
        fill_tide = !fill_tide;
      end
      if ($urandom_range(49) == 0) begin
        value_pool[$urandom_range(PoolSize-1)] = $urandom;
      end
    end
  endtask

  initial begin
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 32'sh0000_0000;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < PoolSize; i++) begin
      value_pool[i] = $urandom;
    end

    repeat (9) @(posedge clk);
    rst_n         <= 1'b1;
    send_idle_pct = 28;
    recv_idle_pct = 48;

    // Directed words: empty lookup, extreme values, duplicates, absent delete,
    // the unused code, swap on delete, then a full table.
    send_word(ust_pkg::REQ_LOOKUP, 32'sd0);
    send_word(ust_pkg::REQ_INSERT, 32'sh8000_0000);
    send_word(ust_pkg::REQ_INSERT, 32'sh7fff_ffff);
    send_word(ust_pkg::REQ_INSERT, -32'sd1);
    send_word(ust_pkg::REQ_INSERT, 32'sh7fff_ffff);
    send_word(ust_pkg::REQ_LOOKUP, -32'sd1);
    send_word(ReqUnused, 32'sh8000_0000);
    send_word(ust_pkg::REQ_DELETE, 32'sd12345);
    send_word(ust_pkg::REQ_DELETE, 32'sh8000_0000);
    send_word(ust_pkg::REQ_LOOKUP, -32'sd1);
    for (int k = 0; k < Capacity - 2; k++) begin
      send_word(ust_pkg::REQ_INSERT, 32'sh5555_0000 + k);
    end
    send_word(ust_pkg::REQ_INSERT, 32'sd0);
    send_word(ust_pkg::REQ_INSERT, 32'sh7fff_ffff);
    send_word(ust_pkg::REQ_DELETE, 32'sh5555_0000 + Capacity - 3);

    run_random(PhaseItems);

    send_idle_pct = 48;
    recv_idle_pct = 28;
    run_random(PhaseItems);

    // Receiver stops for a long stretch while words keep coming, so the input stalls.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_calls <= hold_calls + 1;
    run_random(12);
    run_random(PhaseItems);

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("unordered_set_table test passed");
    end else begin
      $display("unordered_set_table test failed");
    end
    $finish;
  end

endmodule
